FILE: design/c_amvs_pkg.sv
// Shared types, character codes and helpers of the metavariable substituter.
// No dependencies; imported by the lexer, the output buffer and the top level.
`timescale 1ns / 1ps

package c_amvs_pkg;

	localparam int unsigned MaxResults = 10;
	localparam int unsigned CountW     = $clog2(MaxResults + 1);

	// lexical mode of the scanner
	typedef enum logic [2:0] {
		MODE_CODE  = 3'd0,
		MODE_STR   = 3'd1,
		MODE_CHR   = 3'd2,
		MODE_LINE  = 3'd3,
		MODE_BLOCK = 3'd4
	} lex_mode_t;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_RPAREN = 8'h29;

	// capture prefix, first character in the top byte
	localparam int unsigned PrefixLen = 8;
	localparam logic [8*PrefixLen-1:0] CAP_PREFIX = "(*__cap_";

	// results of one input item, head byte at index 0
	typedef struct packed {
		logic [MaxResults-1:0][7:0] bytes;
		logic [CountW-1:0]          count;
		logic                       fin;
	} res_t;

	function automatic logic id_start(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || (c == 8'h5F);
	endfunction

	function automatic logic id_cont(input logic [7:0] c);
		return id_start(c) || (c >= 8'h30 && c <= 8'h39);
	endfunction

endpackage

FILE: design/c_amvs_lexer.sv
// Lexical mode tracker and rewriter: one input byte to up to ten result bytes.
// Depends on c_amvs_pkg.
`timescale 1ns / 1ps

module c_amvs_lexer
	import c_amvs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] text_byte,
	input  logic       text_end,
	output res_t       res
);

	lex_mode_t mode_q, mode_d;
	logic      esc_q, esc_d;
	logic      slash_q, slash_d;
	logic      star_q, star_d;
	logic      dollar_q, dollar_d;
	logic      cap_q, cap_d;

	logic [MaxResults-1:0][7:0] b;
	logic [CountW-1:0]          n;
	logic                       do_code;
	logic                       code_done;

	always_comb begin
		mode_d    = mode_q;
		esc_d     = esc_q;
		slash_d   = slash_q;
		star_d    = star_q;
		dollar_d  = dollar_q;
		cap_d     = cap_q;
		b         = '0;
		n         = '0;
		do_code   = 1'b0;
		code_done = 1'b0;

		case (mode_q)
			MODE_STR, MODE_CHR: begin
				b[n] = text_byte;
				n = n + 1'b1;
				if (esc_q) begin
					esc_d = 1'b0;
				end else if (text_byte == CH_BSLASH) begin
					esc_d = 1'b1;
				end else if (text_byte == ((mode_q == MODE_STR) ? CH_DQUOTE : CH_SQUOTE)) begin
					mode_d = MODE_CODE;
				end
			end
			MODE_LINE: begin
				b[n] = text_byte;
				n = n + 1'b1;
				if (text_byte == CH_NL) begin
					mode_d = MODE_CODE;
				end
			end
			MODE_BLOCK: begin
				b[n] = text_byte;
				n = n + 1'b1;
				if (star_q && text_byte == CH_SLASH) begin
					star_d = 1'b0;
					mode_d = MODE_CODE;
				end else begin
					star_d = (text_byte == CH_STAR);
				end
			end
			default: begin
				mode_d = MODE_CODE;
				if (dollar_q) begin
					dollar_d = 1'b0;
					if (id_start(text_byte)) begin
						for (int k = 0; k < PrefixLen; k++) begin
							b[n] = CAP_PREFIX[8*(PrefixLen-1-k) +: 8];
							n = n + 1'b1;
						end
						b[n] = text_byte;
						n = n + 1'b1;
						cap_d = 1'b1;
					end else begin
						b[n] = CH_DOLLAR;
						n = n + 1'b1;
						do_code = 1'b1;
					end
				end else if (cap_q) begin
					if (id_cont(text_byte)) begin
						b[n] = text_byte;
						n = n + 1'b1;
					end else begin
						cap_d = 1'b0;
						b[n] = CH_RPAREN;
						n = n + 1'b1;
						do_code = 1'b1;
					end
				end else begin
					do_code = 1'b1;
				end

				// ordinary code byte: comment openers, literal openers, held dollar
				if (do_code) begin
					if (slash_q) begin
						slash_d = 1'b0;
						if (text_byte == CH_SLASH) begin
							mode_d = MODE_LINE;
							b[n] = text_byte;
							n = n + 1'b1;
							code_done = 1'b1;
						end else if (text_byte == CH_STAR) begin
							mode_d = MODE_BLOCK;
							star_d = 1'b0;
							b[n] = text_byte;
							n = n + 1'b1;
							code_done = 1'b1;
						end
					end
					if (!code_done) begin
						if (text_byte == CH_DQUOTE || text_byte == CH_SQUOTE) begin
							mode_d = (text_byte == CH_DQUOTE) ? MODE_STR : MODE_CHR;
							esc_d = 1'b0;
							b[n] = text_byte;
							n = n + 1'b1;
						end else if (text_byte == CH_DOLLAR) begin
							dollar_d = 1'b1;
						end else begin
							b[n] = text_byte;
							n = n + 1'b1;
							if (text_byte == CH_SLASH) begin
								slash_d = 1'b1;
							end
						end
					end
				end
			end
		endcase

		// end of fragment: flush held dollar or open name, then back to reset state
		if (text_end) begin
			if (dollar_d) begin
				b[n] = CH_DOLLAR;
				n = n + 1'b1;
			end
			if (cap_d) begin
				b[n] = CH_RPAREN;
				n = n + 1'b1;
			end
			mode_d   = MODE_CODE;
			esc_d    = 1'b0;
			slash_d  = 1'b0;
			star_d   = 1'b0;
			dollar_d = 1'b0;
			cap_d    = 1'b0;
		end
	end

	assign res.bytes = b;
	assign res.count = n;
	assign res.fin   = text_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_CODE;
			esc_q    <= 1'b0;
			slash_q  <= 1'b0;
			star_q   <= 1'b0;
			dollar_q <= 1'b0;
			cap_q    <= 1'b0;
		end else if (take) begin
			mode_q   <= mode_d;
			esc_q    <= esc_d;
			slash_q  <= slash_d;
			star_q   <= star_d;
			dollar_q <= dollar_d;
			cap_q    <= cap_d;
		end
	end

endmodule

FILE: design/c_amvs_outbuf.sv
// Result register: holds one item's bytes, sends one a cycle while ready is high.
// Depends on c_amvs_pkg.
`timescale 1ns / 1ps

module c_amvs_outbuf
	import c_amvs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  res_t       res,
	output logic       load_ok,
	output logic       valid,
	input  logic       ready,
	output logic [7:0] data,
	output logic       last,
	output logic       fin
);

	logic [MaxResults-1:0][7:0] buf_q;
	logic [CountW-1:0]          rem_q;
	logic                       fin_q;
	logic                       load;
	logic                       xfer;

	assign valid   = (rem_q != '0);
	assign xfer    = valid && ready;
	assign load_ok = (rem_q == '0) || (rem_q == CountW'(1) && ready);
	assign load    = take && (res.count != '0);

	assign data = buf_q[0];
	assign last = (rem_q == CountW'(1));
	assign fin  = last && fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= res.count;
		end else if (xfer) begin
			rem_q <= rem_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= res.bytes;
			fin_q <= res.fin;
		end else if (xfer) begin
			buf_q <= {8'h00, buf_q[MaxResults-1:1]};
		end
	end

endmodule

FILE: design/c_aware_metavar_substituter_core.sv
// Latency: the first result byte of an item appears the cycle after its input transfer.
// Throughput: one input byte per cycle while each item yields at most one result byte
//   and m_tready is high; an item with n results holds the output for n transfers,
//   and input stalls until its last result byte leaves.
// The result register drains one byte per output transfer; the next item loads as the
//   last byte leaves, so no bubble between items.
// Reset: arst_n clears the lexical mode to code, all pending flags and the result count.
`timescale 1ns / 1ps

module c_aware_metavar_substituter_core
	import c_amvs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] text_byte
	input  logic       s_tlast,   // text_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] emit_byte
	output logic       m_tlast,   // run_end
	output logic       m_tuser    // [0] output_end
);

	res_t res;
	logic take;
	logic load_ok;

	// accept while the result register is empty or its final byte leaves this cycle
	assign s_tready = load_ok;
	assign take     = s_tvalid && s_tready;

	// mode tracking and rewrite, state advances on each input transfer
	c_amvs_lexer u_lexer (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.text_byte (s_tdata),
		.text_end  (s_tlast),
		.res       (res)
	);

	// hold the expansion and send it out one transfer at a time
	c_amvs_outbuf u_outbuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.res     (res),
		.load_ok (load_ok),
		.valid   (m_tvalid),
		.ready   (m_tready),
		.data    (m_tdata),
		.last    (m_tlast),
		.fin     (m_tuser)
	);

endmodule
